### design/utf8_validating_decoder_macros.svh
// ---------------------------------------------------------------------------
// utf8 decoder assertion macros
// shorthand for the concurrent checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// condition must hold at every edge out of reset
`define UVD_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define UVD_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/utf8vd_pkg.sv
// ---------------------------------------------------------------------------
// utf8vd_pkg
// constants and sequence decode helpers for the utf-8 validating decoder
// ---------------------------------------------------------------------------
`default_nettype none

package utf8vd_pkg;

  localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2    = 21'h000080;
  localparam logic [20:0] MIN_CP3    = 21'h000800;
  localparam logic [20:0] MIN_CP4    = 21'h010000;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_TAG  = 8'hF0;
  localparam logic [7:0]  PAYLOAD6   = 8'h3F;

  // sequence lengths announced by a lead byte
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic        ok;
    logic [20:0] cp;
  } dec_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = LEN_1;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      len = LEN_2;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      len = LEN_3;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      len = LEN_4;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  // decode a complete multibyte sequence of 2 to 4 bytes
  function automatic dec_t decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [2:0] len);
    dec_t        d;
    logic [20:0] c;
    d = '0;
    c = '0;
    unique case (len)
      LEN_2: begin
        c = {10'd0, b0[4:0], b1[5:0]};
        d.ok = is_cont(b1) && (c >= MIN_CP2);
      end
      LEN_3: begin
        c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        d.ok = is_cont(b1) && is_cont(b2) && (c >= MIN_CP3)
               && !((c >= SURR_LO) && (c <= SURR_HI));
      end
      LEN_4: begin
        c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        d.ok = is_cont(b1) && is_cont(b2) && is_cont(b3)
               && (c >= MIN_CP4) && (c <= MAX_CP);
      end
      default: begin
        d.ok = 1'b0;
      end
    endcase
    d.cp = c;
    return d;
  endfunction

endpackage

`default_nettype wire

### design/utf8_validating_decoder.sv
// ---------------------------------------------------------------------------
// utf8_validating_decoder
// streaming utf-8 decoder that replaces malformed input with U+FFFD
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one byte per word; tlast marks the final byte of a string
//   and flushes any held partial sequence. m_axis carries one word per
//   decoded character with its code point, width, index and byte offset;
//   tlast marks the last character of the string.
//   cfg_we/cfg_wdata set the character index flagged in m_axis_tuser[1].
// a final byte is queued, then its character is registered at the output.
// throughput: one byte per cycle for well-formed text while output is free.
//   only one character is decoded per cycle from the four-byte holding queue,
//   so a bad sequence, or one truncated at end of string, holds input while
//   its characters decode, until the queue drains or waits for more bytes.
// reset: queue empty, counters zero, target index zero, no output word.
// stall: a pending output word sits in the output register; while it waits
//   the decoder still takes a byte into an empty queue or a partial sequence.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_validating_decoder_macros.svh"

module utf8_validating_decoder #(
  parameter int COUNTER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  input  wire logic        s_axis_tlast,   // end_of_string
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // code_point[20:0], char_width[23:21], char_index[55:24], byte_offset[87:56]
  output logic [87:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // invalid_seq[0], is_target[1]
  output logic             m_axis_tlast    // last_result
);
  import utf8vd_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;

  // holding queue: pending bytes plus the newest byte
  logic [7:0]              q [4];
  logic [7:0]              q_next [4];
  logic [2:0]              qcount, qcount_next;
  logic                    q_eos, q_eos_next;
  logic [31:0]             target;
  logic [COUNTER_BITS-1:0] char_counter, char_counter_next;
  logic [COUNTER_BITS-1:0] byte_counter, byte_counter_next;

  logic        out_valid;
  logic [20:0] out_cp;
  logic [2:0]  out_width;
  logic        out_inv;
  logic [31:0] out_index;
  logic [31:0] out_offset;
  logic        out_target;
  logic        out_last;

  // head decode
  logic [2:0]  head_len;
  dec_t        head_dec;
  logic        head_emit;
  logic        head_break;
  logic [20:0] head_cp;
  logic [2:0]  head_width;
  logic        head_inv;
  logic        head_last;
  logic        emit_fire;
  logic        in_fire;
  logic [2:0]  count_after;
  logic [7:0]  q_pop [4];
  logic [CMP_W-1:0] char_ext, byte_ext, target_ext;

  always_comb begin
    head_len   = seq_len(q[0]);
    head_dec   = decode_seq(q[0], q[1], q[2], q[3], head_len);
    head_emit  = 1'b0;
    head_break = 1'b0;
    head_cp    = REPL_CHAR;
    head_width = 3'd1;
    head_inv   = 1'b1;
    if (qcount != 3'd0) begin
      priority if (head_len == LEN_1) begin
        head_emit = 1'b1;
        head_cp   = {13'd0, q[0]};
        head_inv  = 1'b0;
      end else if (head_len == LEN_BAD) begin
        head_emit = 1'b1;
      end else if (qcount >= head_len) begin
        head_emit = 1'b1;
        if (head_dec.ok) begin
          head_cp    = head_dec.cp;
          head_width = head_len;
          head_inv   = 1'b0;
        end
      end else if (!q_eos) begin
        head_break = 1'b1;
      end else begin
        // truncated at end of string
        head_emit = 1'b1;
      end
    end
  end

  assign head_last = q_eos && (head_width == qcount);
  assign emit_fire = head_emit && (!out_valid || m_axis_tready);
  assign s_axis_tready = (qcount == 3'd0) || head_break
                         || (emit_fire && (head_width == qcount));
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign count_after = emit_fire ? (qcount - head_width) : qcount;

  always_comb begin
    unique case (head_width)
      3'd2: begin
        q_pop[0] = q[2]; q_pop[1] = q[3]; q_pop[2] = '0; q_pop[3] = '0;
      end
      3'd3: begin
        q_pop[0] = q[3]; q_pop[1] = '0; q_pop[2] = '0; q_pop[3] = '0;
      end
      3'd4: begin
        q_pop[0] = '0; q_pop[1] = '0; q_pop[2] = '0; q_pop[3] = '0;
      end
      default: begin
        q_pop[0] = q[1]; q_pop[1] = q[2]; q_pop[2] = q[3]; q_pop[3] = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_next[i] = emit_fire ? q_pop[i] : q[i];
    end
    qcount_next = count_after;
    q_eos_next  = (count_after == 3'd0) ? 1'b0 : q_eos;
    if (in_fire) begin
      q_next[count_after[1:0]] = s_axis_tdata;
      qcount_next = count_after + 3'd1;
      q_eos_next  = s_axis_tlast;
    end
  end

  assign char_ext   = CMP_W'(char_counter);
  assign byte_ext   = CMP_W'(byte_counter);
  assign target_ext = CMP_W'(target);

  always_comb begin
    char_counter_next = char_counter;
    byte_counter_next = byte_counter;
    if (emit_fire) begin
      if (head_last) begin
        char_counter_next = '0;
        byte_counter_next = '0;
      end else begin
        char_counter_next = char_counter + COUNTER_BITS'(1);
        byte_counter_next = byte_counter + COUNTER_BITS'(head_width);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount       <= '0;
      q_eos        <= 1'b0;
      target       <= '0;
      char_counter <= '0;
      byte_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      qcount       <= qcount_next;
      q_eos        <= q_eos_next;
      char_counter <= char_counter_next;
      byte_counter <= byte_counter_next;
      if (cfg_we) begin
        target <= cfg_wdata;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      q[i] <= q_next[i];
    end
    if (emit_fire) begin
      out_cp     <= head_cp;
      out_width  <= head_width;
      out_inv    <= head_inv;
      out_index  <= char_ext[31:0];
      out_offset <= byte_ext[31:0];
      out_target <= (char_ext == target_ext);
      out_last   <= head_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_offset, out_index, out_width, out_cp};
  assign m_axis_tuser  = {out_target, out_inv};
  assign m_axis_tlast  = out_last;

  `UVD_ALWAYS(a_queue_bound, qcount <= 3'd4, "holding queue over four bytes")
  `UVD_IMPLIES(a_room_on_accept, in_fire, count_after <= 3'd3,
               "byte accepted into a full queue")
  `UVD_NEXT(a_counters_clear, emit_fire && head_last,
            char_counter == '0 && byte_counter == '0,
            "counters not cleared after end of string")
  `UVD_IMPLIES(a_repl_width, m_axis_tvalid && m_axis_tuser[0],
               m_axis_tdata[23:21] == 3'd1 && m_axis_tdata[20:0] == REPL_CHAR,
               "replacement character with wrong width or value")

endmodule

`default_nettype wire

### bench/utf8_validating_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder_tb
// self-checking bench for the streaming utf-8 decoder: bytes go in on
// s_axis, a local decoder predicts every character word, and each word on
// m_axis is matched against the oldest prediction while both sides idle
// and stall at random
// ----------------------------------------------------------------------------
module utf8_validating_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8vd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_GAP   = 12;
  localparam int RANDOM_BYTES = 70;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  width;
    logic        inv;
    logic [31:0] idx;
    logic [31:0] offset;
    logic        hit;
    logic        tail;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;   // code_point, char_width, char_index, byte_offset
  logic [1:0]  m_axis_tuser;   // invalid_seq, is_target
  logic        m_axis_tlast;

  utf8_validating_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // local decoder state
  logic [7:0]  held [3];
  int          held_count = 0;
  logic [31:0] char_count = '0;
  logic [31:0] byte_count = '0;
  logic [31:0] target_index = '0;
  char_t       decoded_chars [$];
  logic [7:0]  text_bytes [$];

  int bytes_sent = 0;
  int strings_sent = 0;
  int chars_seen = 0;
  int repl_seen = 0;
  int hits_seen = 0;
  int errors = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  function automatic int lead_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // full sequence of len bytes starting at b0; returns 1 if well formed
  function automatic logic seq_valid(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input int len, output logic [20:0] cp);
    logic ok;
    ok = is_trail(b1);
    if (len >= 3 && !is_trail(b2)) ok = 1'b0;
    if (len == 4 && !is_trail(b3)) ok = 1'b0;
    if (len == 2) begin
      cp = {10'd0, b0[4:0], b1[5:0]};
      if (cp < MIN_CP2) ok = 1'b0;
    end else if (len == 3) begin
      cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      if (cp < MIN_CP3 || (cp >= SURR_LO && cp <= SURR_HI)) ok = 1'b0;
    end else begin
      cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      if (cp < MIN_CP4 || cp > MAX_CP) ok = 1'b0;
    end
    return ok;
  endfunction

  // predict the characters that one accepted byte releases
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [7:0]  q [8];
    char_t       batch [4];
    logic [20:0] cp;
    logic [2:0]  w;
    logic        inv;
    int          n, head, k, len, i;
    for (i = 0; i < 8; i++) q[i] = '0;
    n = held_count;
    for (i = 0; i < n; i++) q[i] = held[i];
    q[n] = b;
    n++;
    head = 0;
    k = 0;
    while (head < n) begin
      len = lead_len(q[head]);
      cp = REPL_CHAR;
      w = 3'd1;
      inv = 1'b1;
      if (len == 1) begin
        cp = {13'd0, q[head]};
        inv = 1'b0;
      end else if (len >= 2) begin
        if (n - head >= len) begin
          if (seq_valid(q[head], q[head+1], q[head+2], q[head+3], len, cp)) begin
            w = 3'(len);
            inv = 1'b0;
          end else begin
            cp = REPL_CHAR;
          end
        end else if (!eos) begin
          break;
        end
      end
      batch[k] = '{cp, w, inv, char_count, byte_count, char_count == target_index, 1'b0};
      char_count += 1;
      byte_count += 32'(w);
      k++;
      head += w;
    end
    held_count = n - head;
    for (i = 0; i < held_count; i++) held[i] = q[head+i];
    if (eos) begin
      if (k > 0) batch[k-1].tail = 1'b1;
      char_count = '0;
      byte_count = '0;
      held_count = 0;
    end
    for (i = 0; i < k; i++) decoded_chars.push_back(batch[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_bytes.size(); i++) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
    strings_sent++;
  endtask

  // stop sending, let every predicted word come out, then a few quiet cycles
  task automatic drain(input int cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (decoded_chars.size() != 0) @(posedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_target(input logic [31:0] value);
    drain(DRAIN_GAP);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    target_index = value;
  endtask

  // push one character in a forced length, overlong forms included
  task automatic put_utf8(input logic [20:0] cp, input int len);
    case (len)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // mostly well-formed characters, the rest malformed in assorted ways
  task automatic add_random_char();
    int          kind, len, pos, drop;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      put_utf8(21'($urandom_range(0, 127)), 1);
    end else if (kind < 45) begin
      put_utf8(21'($urandom_range(32'h80, 32'h7FF)), 2);
    end else if (kind < 60) begin
      put_utf8(21'($urandom_range(32'h800, 32'hFFFF)), 3);
    end else if (kind < 75) begin
      put_utf8(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    end else if (kind < 80) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 84) begin
      text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 88) begin
      // overlong form
      cp = 21'($urandom_range(0, 32'h7FF));
      len = (cp < 21'h80) ? $urandom_range(2, 4) : $urandom_range(3, 4);
      put_utf8(cp, len);
    end else if (kind < 91) begin
      put_utf8(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
    end else if (kind < 94) begin
      put_utf8(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
    end else if (kind < 97) begin
      // truncated sequence
      len = $urandom_range(2, 4);
      put_utf8(21'($urandom_range(32'h800, 32'h10FFFF)), len);
      drop = $urandom_range(1, len - 1);
      repeat (drop) void'(text_bytes.pop_back());
    end else begin
      // broken continuation
      len = $urandom_range(2, 4);
      put_utf8(21'($urandom_range(32'h10000, 32'h10FFFF)), len);
      pos = text_bytes.size() - $urandom_range(1, len - 1);
      text_bytes[pos] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                             : 8'($urandom_range(8'hC0, 8'hFF));
    end
  endtask

  // target flag at its reset index, plus width edges 00, 7F, 0080, FFFF, 10FFFF
  task automatic test_valid_chars();
    text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
  endtask

  task automatic test_invalid_leads();
    write_target(32'd1);
    text_bytes = '{8'h80, 8'hFF};
    send_text();
  endtask

  // overlong, surrogate, above the code space, non-continuation trailer
  task automatic test_bad_sequences();
    write_target(32'hFFFF_FFFF);
    text_bytes = '{8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                   8'hE2, 8'h41};
    send_text();
  endtask

  // string ends in the middle of a four-byte sequence
  task automatic test_truncation();
    write_target(32'd2);
    text_bytes = '{8'hF0, 8'h90, 8'h80};
    send_text();
  endtask

  task automatic test_random_text();
    int          phase, start, nchars;
    logic [31:0] value;
    phase = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      case (phase % 5)
        0:       value = 32'd0;
        1:       value = 32'hFFFF_FFFF;
        2:       value = $urandom;
        default: value = $urandom_range(0, 7);
      endcase
      write_target(value);
      steady = (phase % 4 == 3);
      repeat (4) begin
        nchars = $urandom_range(1, 8);
        repeat (nchars) add_random_char();
        send_text();
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // receiver stalls: always ready, coin toss, or a rotating mask
  int         rx_mode = 0;
  int         rx_left = 0;
  logic [7:0] rx_mask = 8'hFF;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = steady ? 0 : $urandom_range(0, 2);
      rx_left = $urandom_range(16, 64);
      rx_mask = 8'($urandom) | 8'h01;
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        m_axis_tready <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
    endcase
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    char_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[20:0], m_axis_tdata[23:21], m_axis_tuser[0],
              m_axis_tdata[55:24], m_axis_tdata[87:56], m_axis_tuser[1], m_axis_tlast};
      chars_seen++;
      if (got.inv) repl_seen++;
      if (got.hit) hits_seen++;
      if (decoded_chars.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word cp=%h idx=%0d", got.cp, got.idx);
      end else begin
        want = decoded_chars.pop_front();
        if (got.cp !== want.cp || got.width !== want.width || got.inv !== want.inv ||
            got.idx !== want.idx || got.offset !== want.offset ||
            got.hit !== want.hit || got.tail !== want.tail) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp cp=%h w=%0d inv=%b idx=%0d off=%0d hit=%b last=%b",
                     want.cp, want.width, want.inv, want.idx, want.offset, want.hit,
                     want.tail);
            $display("         got cp=%h w=%0d inv=%b idx=%0d off=%0d hit=%b last=%b",
                     got.cp, got.width, got.inv, got.idx, got.offset, got.hit, got.tail);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word moved for %0d cycles, %0d predictions left",
                 idle_cycles, decoded_chars.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_valid_chars();
    test_invalid_leads();
    test_bad_sequences();
    test_truncation();
    test_random_text();
    drain(DRAIN_GAP);
    $display("sent %0d bytes in %0d strings under several target indexes",
             bytes_sent, strings_sent);
    $display("checked %0d characters, %0d replacements, %0d target hits",
             chars_seen, repl_seen, hits_seen);
    if (errors == 0 && decoded_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/utf8vd_pkg.sv
design/utf8_validating_decoder.sv
bench/utf8_validating_decoder_tb.sv
